FILE: sv/htpo_pkg.sv
// shared types and constants for the hit time to position offset block
package htpo_pkg;

   localparam int COEF_W = 32;
   localparam int TIME_W = 32;
   localparam int ID_W = 12;
   localparam int CSR_IDX_W = 3;
   localparam int ROOT_W = 40;
   localparam int RAD_W = 2 * ROOT_W;
   localparam int DISC_W = 77;
   localparam int NUM_W = 42;
   localparam int QUOT_W = 32;
   localparam int DIVR_W = 33;

   localparam logic signed [31:0] FALLBACK_OFFSET = -32'sd1638400;
   localparam logic signed [31:0] OFFSET_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] OFFSET_MIN = 32'sh8000_0000;

   localparam logic signed [31:0] P0_QUAD_RESET = -32'sd6291;
   localparam logic signed [31:0] P0_LIN_RESET = -32'sd858732;
   localparam logic signed [31:0] P0_CONST_RESET = 32'sd60280336;
   localparam logic signed [31:0] P1_QUAD_RESET = -32'sd6863;
   localparam logic signed [31:0] P1_LIN_RESET = -32'sd846467;
   localparam logic signed [31:0] P1_CONST_RESET = 32'sd76118360;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_P0_QUAD  = 3'd0,
      REG_P0_LIN   = 3'd1,
      REG_P0_CONST = 3'd2,
      REG_P1_QUAD  = 3'd3,
      REG_P1_LIN   = 3'd4,
      REG_P1_CONST = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic side;
      logic found;
      logic signed [COEF_W-1:0] quad;
      logic signed [COEF_W-1:0] lin;
   } sqrt_side_type;

   typedef struct packed {
      logic side;
      logic found;
      logic az;
      logic neg;
      logic ovf;
   } div_side_type;

endpackage

FILE: sv/hit_time_to_position_offset.sv
// top level: hit time to position offset along a bar
// one hit word is taken every clock unless the output stalls; results come out in order
// via decode, coefficient select, multiply, product sum, discriminant, a 40-stage square
// root, numerator, divider setup, a 32-stage divider and the output register. the whole
// pipeline advances together and holds while the output word waits, so the rate is one
// word per cycle whenever rsp_tready is high. coefficients are to be written through the
// csr port only while no hit is in flight; the block itself does not enforce this.
module hit_time_to_position_offset #(
   parameter int PADDLES_PER_BAR = 14,
   parameter int BARS_PER_SIDE = 14,
   parameter int MODULES_PER_PLANE = 3
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // channel_id [11:0], hit_time [43:12], zero pad [47:44]
   input  logic [47:0]                          req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // position_offset [31:0]
   output logic [31:0]                          rsp_tdata,
   // root_found [0]
   output logic [0:0]                           rsp_tuser,
   input  logic                                 csr_wr_en,
   input  logic [htpo_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [htpo_pkg::COEF_W-1:0]          csr_wdata
);

   localparam longint SideDiv = longint'(PADDLES_PER_BAR) * longint'(BARS_PER_SIDE);
   localparam longint PlaneDiv = SideDiv * 2 * longint'(MODULES_PER_PLANE);
   localparam logic [32:0] SIDE_RECIP = 33'(((64'd1 << 32) + SideDiv - 1) / SideDiv);
   localparam logic [32:0] PLANE_RECIP = 33'(((64'd1 << 32) + PlaneDiv - 1) / PlaneDiv);

   logic en;
   logic req_accept;

   logic signed [31:0] quad_ff [0:1];
   logic signed [31:0] lin_ff [0:1];
   logic signed [31:0] const_ff [0:1];

   logic [htpo_pkg::ID_W-1:0] chan;
   logic [44:0] side_prod;
   logic [44:0] plane_prod;

   logic v1_ff, side1_ff, plane1_ff;
   logic signed [31:0] t1_ff;

   logic v2_ff, side2_ff;
   logic signed [31:0] a2_ff, b2_ff;
   logic signed [40:0] d2_ff, d2_in;

   logic v3_ff, side3_ff;
   logic signed [31:0] a3_ff, b3_ff;
   logic signed [64:0] pl3_ff, pl3_in;
   logic signed [40:0] ph3_ff, ph3_in;
   logic signed [63:0] bb3_ff, bb3_in;

   logic v4_ff, side4_ff;
   logic signed [31:0] a4_ff, b4_ff;
   logic [72:0] ad4_ff, ad4_in;
   logic [63:0] bb4_ff;

   logic v5_ff, side5_ff;
   logic signed [31:0] a5_ff, b5_ff;
   logic [htpo_pkg::DISC_W-1:0] disc5_ff, disc5_in;

   htpo_pkg::sqrt_side_type sq_in_side, sq_out_side;
   logic sq_out_valid;
   logic [htpo_pkg::ROOT_W-1:0] sq_root;

   logic v6_ff;
   htpo_pkg::sqrt_side_type side6_ff;
   logic [htpo_pkg::NUM_W-1:0] num6_ff, num6_in;

   logic v7_ff;
   logic [htpo_pkg::DIVR_W-1:0] rem7_ff, rem7_in;
   logic [htpo_pkg::QUOT_W-1:0] low7_ff, low7_in;
   logic [htpo_pkg::DIVR_W-1:0] dvs7_ff, dvs7_in;
   htpo_pkg::div_side_type side7_ff, side7_in;
   logic [htpo_pkg::NUM_W-1:0] nabs;
   logic [31:0] abs_a;

   logic dv_out_valid;
   logic [htpo_pkg::QUOT_W-1:0] dv_quot;
   htpo_pkg::div_side_type dv_side;

   logic rsp_valid_ff;
   logic [31:0] offset_ff, offset_in;
   logic found_ff;
   logic [31:0] qv;

   assign en = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign req_accept = req_tvalid && en;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         quad_ff[0] <= htpo_pkg::P0_QUAD_RESET;
         lin_ff[0] <= htpo_pkg::P0_LIN_RESET;
         const_ff[0] <= htpo_pkg::P0_CONST_RESET;
         quad_ff[1] <= htpo_pkg::P1_QUAD_RESET;
         lin_ff[1] <= htpo_pkg::P1_LIN_RESET;
         const_ff[1] <= htpo_pkg::P1_CONST_RESET;
      end else if (csr_wr_en) begin
         unique case (htpo_pkg::reg_index_type'(csr_index))
            htpo_pkg::REG_P0_QUAD: quad_ff[0] <= csr_wdata;
            htpo_pkg::REG_P0_LIN: lin_ff[0] <= csr_wdata;
            htpo_pkg::REG_P0_CONST: const_ff[0] <= csr_wdata;
            htpo_pkg::REG_P1_QUAD: quad_ff[1] <= csr_wdata;
            htpo_pkg::REG_P1_LIN: lin_ff[1] <= csr_wdata;
            htpo_pkg::REG_P1_CONST: const_ff[1] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // channel decode by reciprocal multiply
   assign chan = req_tdata[11:0];
   assign side_prod = {33'd0, chan} * {12'd0, SIDE_RECIP};
   assign plane_prod = {33'd0, chan} * {12'd0, PLANE_RECIP};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_comb begin
      d2_in = {{9{const_ff[plane1_ff][31]}}, const_ff[plane1_ff]} - {t1_ff[31], t1_ff, 8'h00};
      pl3_in = a2_ff * $signed({1'b0, d2_ff[31:0]});
      ph3_in = a2_ff * $signed(d2_ff[40:32]);
      bb3_in = b2_ff * b2_ff;
      ad4_in = {ph3_ff, 32'h0} + {{8{pl3_ff[64]}}, pl3_ff};
      disc5_in = {13'd0, bb4_ff} - {{2{ad4_ff[72]}}, ad4_ff, 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side_prod[32];
         plane1_ff <= plane_prod[32];
         t1_ff <= req_tdata[43:12];
         side2_ff <= side1_ff;
         a2_ff <= quad_ff[plane1_ff];
         b2_ff <= lin_ff[plane1_ff];
         d2_ff <= d2_in;
         side3_ff <= side2_ff;
         a3_ff <= a2_ff;
         b3_ff <= b2_ff;
         pl3_ff <= pl3_in;
         ph3_ff <= ph3_in;
         bb3_ff <= bb3_in;
         side4_ff <= side3_ff;
         a4_ff <= a3_ff;
         b4_ff <= b3_ff;
         ad4_ff <= ad4_in;
         bb4_ff <= bb3_ff;
         side5_ff <= side4_ff;
         a5_ff <= a4_ff;
         b5_ff <= b4_ff;
         disc5_ff <= disc5_in;
      end
   end

   always_comb begin
      sq_in_side.side = side5_ff;
      sq_in_side.found = !disc5_ff[htpo_pkg::DISC_W-1];
      sq_in_side.quad = a5_ff;
      sq_in_side.lin = b5_ff;
   end

   htpo_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_rad    ({3'd0, disc5_ff}),
      .in_side   (sq_in_side),
      .out_valid (sq_out_valid),
      .out_root  (sq_root),
      .out_side  (sq_out_side)
   );

   // numerator and divider setup
   always_comb begin
      num6_in = -{{10{sq_out_side.lin[31]}}, sq_out_side.lin} - {2'b00, sq_root};
      nabs = num6_ff[htpo_pkg::NUM_W-1] ? -num6_ff : num6_ff;
      abs_a = side6_ff.quad[31] ? -side6_ff.quad : side6_ff.quad;
      dvs7_in = {abs_a, 1'b0};
      rem7_in = {7'd0, nabs[41:16]};
      low7_in = {nabs[15:0], 16'h0};
      side7_in.side = side6_ff.side;
      side7_in.found = side6_ff.found;
      side7_in.az = (side6_ff.quad == '0);
      side7_in.neg = num6_ff[htpo_pkg::NUM_W-1] ^ side6_ff.quad[31] ^ side6_ff.side;
      // zero quadratic: only a negative numerator runs off to the limit
      side7_in.ovf = (side6_ff.quad == '0) ? num6_ff[htpo_pkg::NUM_W-1] :
                     (rem7_in >= dvs7_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= sq_out_valid;
         v7_ff <= v6_ff;
      end
      if (en) begin
         side6_ff <= sq_out_side;
         num6_ff <= num6_in;
         rem7_ff <= rem7_in;
         low7_ff <= low7_in;
         dvs7_ff <= dvs7_in;
         side7_ff <= side7_in;
      end
   end

   htpo_div u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (v7_ff),
      .in_rem     (rem7_ff),
      .in_low     (low7_ff),
      .in_divisor (dvs7_ff),
      .in_side    (side7_ff),
      .out_valid  (dv_out_valid),
      .out_quot   (dv_quot),
      .out_side   (dv_side)
   );

   // sign, saturation and fallback
   always_comb begin
      qv = dv_side.az ? '0 : dv_quot;
      if (!dv_side.found) begin
         offset_in = dv_side.side ? -htpo_pkg::FALLBACK_OFFSET : htpo_pkg::FALLBACK_OFFSET;
      end else if (dv_side.neg) begin
         offset_in = (dv_side.ovf || qv > 32'h8000_0000) ? htpo_pkg::OFFSET_MIN : -qv;
      end else begin
         offset_in = (dv_side.ovf || qv[31]) ? htpo_pkg::OFFSET_MAX : qv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_out_valid;
      end
      if (en) begin
         offset_ff <= offset_in;
         found_ff <= dv_side.found;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = offset_ff;
   assign rsp_tuser = found_ff;

   a_fallback_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         (rsp_tdata == htpo_pkg::FALLBACK_OFFSET || rsp_tdata == -htpo_pkg::FALLBACK_OFFSET))
      else $error("fallback word carries wrong offset");

   a_div_precondition: assert property (@(posedge clock) disable iff (reset)
      v7_ff && side7_ff.found && !side7_ff.ovf && !side7_ff.az |-> rem7_ff < dvs7_ff)
      else $error("divider started with remainder not below divisor");

   a_stall_backs_up: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v7_ff) && $stable(num6_ff))
      else $error("pipeline moved during stall");

endmodule

FILE: sv/htpo_sqrt.sv
// pipelined integer square root, one root bit per stage
module htpo_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [htpo_pkg::RAD_W-1:0]        in_rad,
   input  htpo_pkg::sqrt_side_type           in_side,
   output logic                              out_valid,
   output logic [htpo_pkg::ROOT_W-1:0]       out_root,
   output htpo_pkg::sqrt_side_type           out_side
);

   localparam int RW = htpo_pkg::ROOT_W;
   localparam int REM_W = RW + 3;

   logic                          v_ff    [0:RW-1];
   logic [htpo_pkg::RAD_W-1:0]    rad_ff  [0:RW-1];
   logic [REM_W-1:0]              rem_ff  [0:RW-1];
   logic [RW-1:0]                 root_ff [0:RW-1];
   htpo_pkg::sqrt_side_type       side_ff [0:RW-1];

   logic                          v_src    [0:RW-1];
   logic [htpo_pkg::RAD_W-1:0]    rad_src  [0:RW-1];
   logic [REM_W-1:0]              rem_src  [0:RW-1];
   logic [RW-1:0]                 root_src [0:RW-1];
   htpo_pkg::sqrt_side_type       side_src [0:RW-1];

   assign v_src[0] = in_valid;
   assign rad_src[0] = in_rad;
   assign rem_src[0] = '0;
   assign root_src[0] = '0;
   assign side_src[0] = in_side;

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      logic             take;
      logic [REM_W-1:0] rem_in;
      logic [RW-1:0]    root_in;

      if (k > 0) begin : g_link
         assign v_src[k] = v_ff[k-1];
         assign rad_src[k] = rad_ff[k-1];
         assign rem_src[k] = rem_ff[k-1];
         assign root_src[k] = root_ff[k-1];
         assign side_src[k] = side_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_src[k][REM_W-3:0], rad_src[k][htpo_pkg::RAD_W-1 -: 2]};
         trial = {1'b0, root_src[k], 2'b01};
         take = (rem_sh >= trial);
         rem_in = take ? (rem_sh - trial) : rem_sh;
         root_in = {root_src[k][RW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src[k];
         end
         if (en) begin
            rad_ff[k] <= {rad_src[k][htpo_pkg::RAD_W-3:0], 2'b00};
            rem_ff[k] <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign out_valid = v_ff[RW-1];
   assign out_root = root_ff[RW-1];
   assign out_side = side_ff[RW-1];

endmodule

FILE: sv/htpo_div.sv
// pipelined restoring divider, one quotient bit per stage
module htpo_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [htpo_pkg::DIVR_W-1:0]       in_rem,
   input  logic [htpo_pkg::QUOT_W-1:0]       in_low,
   input  logic [htpo_pkg::DIVR_W-1:0]       in_divisor,
   input  htpo_pkg::div_side_type            in_side,
   output logic                              out_valid,
   output logic [htpo_pkg::QUOT_W-1:0]       out_quot,
   output htpo_pkg::div_side_type            out_side
);

   localparam int QW = htpo_pkg::QUOT_W;
   localparam int DW = htpo_pkg::DIVR_W;

   logic            v_ff    [0:QW-1];
   logic [DW-1:0]   rem_ff  [0:QW-1];
   logic [QW-1:0]   low_ff  [0:QW-1];
   logic [QW-1:0]   quot_ff [0:QW-1];
   logic [DW-1:0]   dvs_ff  [0:QW-1];
   htpo_pkg::div_side_type side_ff [0:QW-1];

   logic            v_src    [0:QW-1];
   logic [DW-1:0]   rem_src  [0:QW-1];
   logic [QW-1:0]   low_src  [0:QW-1];
   logic [QW-1:0]   quot_src [0:QW-1];
   logic [DW-1:0]   dvs_src  [0:QW-1];
   htpo_pkg::div_side_type side_src [0:QW-1];

   assign v_src[0] = in_valid;
   assign rem_src[0] = in_rem;
   assign low_src[0] = in_low;
   assign quot_src[0] = '0;
   assign dvs_src[0] = in_divisor;
   assign side_src[0] = in_side;

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DW:0]   rem_sh;
      logic          take;
      logic [DW:0]   diff;

      if (k > 0) begin : g_link
         assign v_src[k] = v_ff[k-1];
         assign rem_src[k] = rem_ff[k-1];
         assign low_src[k] = low_ff[k-1];
         assign quot_src[k] = quot_ff[k-1];
         assign dvs_src[k] = dvs_ff[k-1];
         assign side_src[k] = side_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_src[k], low_src[k][QW-1]};
         take = (rem_sh >= {1'b0, dvs_src[k]});
         diff = rem_sh - {1'b0, dvs_src[k]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src[k];
         end
         if (en) begin
            rem_ff[k] <= take ? diff[DW-1:0] : rem_sh[DW-1:0];
            low_ff[k] <= {low_src[k][QW-2:0], 1'b0};
            quot_ff[k] <= {quot_src[k][QW-2:0], take};
            dvs_ff[k] <= dvs_src[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_quot = quot_ff[QW-1];
   assign out_side = side_ff[QW-1];

endmodule
